>>> hw/rtl/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// shared widths, constants and the result record of the string deframer
// ----------------------------------------------------------------------------
package lpsd_pkg;

   localparam int HEADER_DIGITS_DEFAULT = 3;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               end_of_word;
      logic               end_of_message;
      logic [COUNT_W-1:0] word_number;
      logic               header_error;
   } result_type;

endpackage

>>> hw/rtl/lpsd_parser.sv
// ----------------------------------------------------------------------------
// lpsd_parser
// framing state and the per-byte step: headers, payload, markers and errors
// ----------------------------------------------------------------------------
module lpsd_parser import lpsd_pkg::*; #(
   parameter int HEADER_DIGITS = HEADER_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] in_byte,
   output logic              res_valid,
   output result_type        res
);

   localparam int DP_W = (HEADER_DIGITS > 1) ? $clog2(HEADER_DIGITS) : 1;
   localparam logic [DP_W-1:0] DP_LAST = DP_W'(HEADER_DIGITS - 1);
   localparam int ACC_W = COUNT_W + 5;

   localparam logic [1:0] PH_COUNT   = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

   logic [1:0]         phase_ff, phase_in;
   logic [DP_W-1:0]    digit_pos_ff, digit_pos_in;
   logic [COUNT_W-1:0] header_ff, header_in;
   logic [COUNT_W-1:0] words_left_ff, words_left_in;
   logic [COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [COUNT_W-1:0] word_ff, word_in;

   logic               is_digit;
   logic [ACC_W-1:0]   acc;
   logic [COUNT_W-1:0] header_next;
   logic [COUNT_W-1:0] words_dec;
   logic               last_byte;
   logic               last_word;

   assign is_digit    = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_NINE);
   assign acc         = ACC_W'(header_ff) * ACC_W'(10) + ACC_W'(in_byte[3:0]);
   assign header_next = (acc > ACC_W'(COUNT_MAX)) ? COUNT_MAX : acc[COUNT_W-1:0];
   assign words_dec   = (words_left_ff != '0) ? words_left_ff - 1'b1 : words_left_ff;
   assign last_byte   = (bytes_left_ff <= COUNT_W'(1));
   assign last_word   = (words_left_ff <= COUNT_W'(1));

   always_comb begin
      phase_in      = phase_ff;
      digit_pos_in  = digit_pos_ff;
      header_in     = header_ff;
      words_left_in = words_left_ff;
      bytes_left_in = bytes_left_ff;
      word_in       = word_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (phase_ff == PH_PAYLOAD) begin
         res_valid          = 1'b1;
         res.out_byte       = in_byte;
         res.byte_valid     = 1'b1;
         res.end_of_word    = last_byte;
         res.end_of_message = last_byte && last_word;
         res.word_number    = word_ff;
         if (bytes_left_ff != '0) begin
            bytes_left_in = bytes_left_ff - 1'b1;
         end
         if (last_byte) begin
            // close the word, and the message with the last one
            words_left_in = words_dec;
            word_in       = word_ff + 1'b1;
            phase_in      = PH_LENGTH;
            if (words_dec == '0) begin
               phase_in      = PH_COUNT;
               digit_pos_in  = '0;
               header_in     = '0;
               bytes_left_in = '0;
               word_in       = '0;
            end
         end
      end else begin
         if (phase_ff != PH_LENGTH) begin
            phase_in = PH_COUNT;
         end
         if (!is_digit) begin
            res_valid          = 1'b1;
            res.header_error   = 1'b1;
            phase_in      = PH_COUNT;
            digit_pos_in  = '0;
            header_in     = '0;
            words_left_in = '0;
            bytes_left_in = '0;
            word_in       = '0;
         end else if (digit_pos_ff != DP_LAST) begin
            header_in    = header_next;
            digit_pos_in = digit_pos_ff + 1'b1;
         end else begin
            digit_pos_in = '0;
            header_in    = '0;
            if (phase_ff != PH_LENGTH) begin
               if (header_next == '0) begin
                  res_valid          = 1'b1;
                  res.end_of_message = 1'b1;
               end else begin
                  words_left_in = header_next;
                  word_in       = '0;
                  phase_in      = PH_LENGTH;
               end
            end else if (header_next == '0) begin
               // empty word marker
               res_valid          = 1'b1;
               res.end_of_word    = 1'b1;
               res.end_of_message = last_word;
               res.word_number    = word_ff;
               words_left_in = words_dec;
               word_in       = word_ff + 1'b1;
               phase_in      = PH_LENGTH;
               if (words_dec == '0) begin
                  phase_in      = PH_COUNT;
                  bytes_left_in = '0;
                  word_in       = '0;
               end
            end else begin
               bytes_left_in = header_next;
               phase_in      = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COUNT;
         digit_pos_ff  <= '0;
         header_ff     <= '0;
         words_left_ff <= '0;
         bytes_left_ff <= '0;
         word_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         digit_pos_ff  <= digit_pos_in;
         header_ff     <= header_in;
         words_left_ff <= words_left_in;
         bytes_left_ff <= bytes_left_in;
         word_ff       <= word_in;
      end
   end

endmodule

>>> hw/rtl/lpsd_out_reg.sv
// ----------------------------------------------------------------------------
// lpsd_out_reg
// result register with valid/stall handshake toward the consumer
// ----------------------------------------------------------------------------
module lpsd_out_reg import lpsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       free,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> hw/rtl/length_prefixed_string_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer
// splits a decimal length-prefixed byte stream into words
// ----------------------------------------------------------------------------
// A message opens with HEADER_DIGITS ASCII digits giving the word count; each
// word opens with HEADER_DIGITS digits giving its length, then its payload
// bytes. Every payload byte comes out with its word index and end-of-word and
// end-of-message flags; an empty word gives one marker, a zero count gives one
// end-of-message marker, and a non-digit header byte gives an error and
// restarts the parser. Header digits otherwise give no response. Requests
// land in an input register, are parsed there and their responses go to an
// output register; one request is taken and one byte goes through per cycle
// as long as the response side does not stall.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer import lpsd_pkg::*; #(
   parameter int HEADER_DIGITS = HEADER_DIGITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_end_of_word,
   output logic               rsp_end_of_message,
   output logic [COUNT_W-1:0] rsp_word_number,
   output logic               rsp_header_error
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_free;
   logic              advance;
   logic              accept;
   logic              res_valid;
   result_type        res;
   result_type        rsp_data;

   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
   end

   lpsd_parser #(
      .HEADER_DIGITS (HEADER_DIGITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   lpsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .load_data (res),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte       = rsp_data.out_byte;
   assign rsp_byte_valid     = rsp_data.byte_valid;
   assign rsp_end_of_word    = rsp_data.end_of_word;
   assign rsp_end_of_message = rsp_data.end_of_message;
   assign rsp_word_number    = rsp_data.word_number;
   assign rsp_header_error   = rsp_data.header_error;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the length-prefixed string deframer
// ----------------------------------------------------------------------------
// A short table of hand-built requests (digit boundaries, zero count, empty
// word, last payload byte, bad headers) is followed by random framed messages
// with random content, broken headers and raw noise bytes. A behavioral parser
// in the bench predicts every response that the table does not give by hand.
// Both sides idle and stall at random, the response side holds off once for a
// long stretch and the request side drains once. A watchdog ends the run if
// nothing moves.
module tb_top import lpsd_pkg::*; ();

   localparam int          DIGITS      = HEADER_DIGITS_DEFAULT;
   localparam int          ITEMS       = 1150;
   localparam int          HOLD_CYCLES = 300;
   localparam int          LIMIT       = 4000;
   localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
   localparam logic [7:0]  DIGIT_NINE  = 8'h39;

   localparam result_type NO_RSP      = '0;
   localparam result_type HDR_ERR     = '{8'h00, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1};
   localparam result_type ZERO_COUNT  = '{8'h00, 1'b0, 1'b0, 1'b1, 10'd0, 1'b0};
   localparam result_type EMPTY_FIRST = '{8'h00, 1'b0, 1'b1, 1'b0, 10'd0, 1'b0};
   localparam result_type LAST_FF     = '{8'hff, 1'b1, 1'b1, 1'b1, 10'd1, 1'b0};

   typedef enum logic [1:0] {
      PARSE_COUNT   = 2'd0,
      PARSE_LENGTH  = 2'd1,
      PARSE_PAYLOAD = 2'd2
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       typed;
      logic       has_rsp;
      result_type rsp;
   } dir_row_type;

   localparam dir_row_type DIRECTED [21] = '{
      '{8'h00, 1'b1, 1'b1, HDR_ERR},
      '{8'hff, 1'b1, 1'b1, HDR_ERR},
      '{8'h2f, 1'b1, 1'b1, HDR_ERR},
      '{8'h3a, 1'b1, 1'b1, HDR_ERR},
      '{"0",   1'b1, 1'b0, NO_RSP},
      '{"0",   1'b1, 1'b0, NO_RSP},
      '{"0",   1'b1, 1'b1, ZERO_COUNT},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"2",   1'b0, 1'b0, NO_RSP},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"0",   1'b1, 1'b1, EMPTY_FIRST},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"0",   1'b0, 1'b0, NO_RSP},
      '{"1",   1'b0, 1'b0, NO_RSP},
      '{8'hff, 1'b1, 1'b1, LAST_FF},
      '{"9",   1'b0, 1'b0, NO_RSP},
      '{"9",   1'b0, 1'b0, NO_RSP},
      '{"9",   1'b0, 1'b0, NO_RSP},
      '{8'h7a, 1'b1, 1'b1, HDR_ERR}
   };

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_in_byte    = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_byte_valid;
   logic               rsp_end_of_word;
   logic               rsp_end_of_message;
   logic [COUNT_W-1:0] rsp_word_number;
   logic               rsp_header_error;

   // hand-typed expectation riding along with the request
   logic       tag_typed   = 1'b0;
   logic       tag_has_rsp = 1'b0;
   result_type tag_rsp     = '0;

   // parser state of the bench
   parse_phase_type    phase_q      = PARSE_COUNT;
   int unsigned        digits_taken = 0;
   int unsigned        header_acc   = 0;
   logic [COUNT_W-1:0] words_left   = '0;
   logic [COUNT_W-1:0] bytes_left   = '0;
   logic [COUNT_W-1:0] word_idx     = '0;

   result_type expected_words_q [$];

   bit tx_calm       = 1'b0;
   bit rx_calm       = 1'b0;
   bit hold_off_req  = 1'b0;
   int unsigned n_sent = 0;
   int unsigned n_req = 0, n_rsp = 0, n_payload = 0, n_empty = 0, n_zero_count = 0;
   int unsigned n_hdr_err = 0, n_msg_end = 0, max_word = 0, n_fail = 0, idle_cycles = 0;

   length_prefixed_string_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_word    (rsp_end_of_word),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_word_number    (rsp_word_number),
      .rsp_header_error   (rsp_header_error)
   );

   always #1 clock = ~clock;

   function automatic void clear_parser();
      phase_q      = PARSE_COUNT;
      digits_taken = 0;
      header_acc   = 0;
      words_left   = '0;
      bytes_left   = '0;
      word_idx     = '0;
   endfunction

   function automatic void close_word();
      if (words_left > 0) words_left--;
      word_idx = word_idx + 1'b1;
      phase_q  = PARSE_LENGTH;
      if (words_left == 0) clear_parser();
   endfunction

   // advances the bench parser by one byte, returns 1 when a response is due
   function automatic bit deframe_byte(input logic [7:0] b, output result_type r);
      logic               last;
      logic [COUNT_W-1:0] v;
      r = '0;
      if (phase_q == PARSE_PAYLOAD) begin
         last             = (bytes_left <= 1);
         r.out_byte       = b;
         r.byte_valid     = 1'b1;
         r.end_of_word    = last;
         r.end_of_message = last && (words_left <= 1);
         r.word_number    = word_idx;
         if (bytes_left > 0) bytes_left--;
         if (last) close_word();
         return 1'b1;
      end
      if (phase_q != PARSE_LENGTH) phase_q = PARSE_COUNT;
      if (b < DIGIT_ZERO || b > DIGIT_NINE) begin
         r.header_error = 1'b1;
         clear_parser();
         return 1'b1;
      end
      header_acc = header_acc * 10 + 32'(b - DIGIT_ZERO);
      if (header_acc > COUNT_MAX) header_acc = 32'(COUNT_MAX);
      digits_taken++;
      if (digits_taken < DIGITS) return 1'b0;
      v            = header_acc[COUNT_W-1:0];
      digits_taken = 0;
      header_acc   = 0;
      if (phase_q == PARSE_COUNT) begin
         if (v == 0) begin
            r.end_of_message = 1'b1;
            return 1'b1;
         end
         words_left = v;
         word_idx   = '0;
         phase_q    = PARSE_LENGTH;
         return 1'b0;
      end
      if (v == 0) begin
         r.end_of_word    = 1'b1;
         r.end_of_message = (words_left <= 1);
         r.word_number    = word_idx;
         close_word();
         return 1'b1;
      end
      bytes_left = v;
      phase_q    = PARSE_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic drive_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input logic has_rsp = 1'b0, input result_type r = '0);
      int unsigned gap;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      tag_typed   <= typed;
      tag_has_rsp <= has_rsp;
      tag_rsp     <= r;
      n_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   // header digits of n, most significant first; a non-digit replaces bad_pos
   task automatic send_number(input int unsigned n, input int bad_pos);
      int unsigned div;
      logic [7:0]  b;
      div = 10 ** (DIGITS - 1);
      for (int i = 0; i < DIGITS; i++) begin
         if (i == bad_pos) begin
            do b = 8'($urandom_range(0, 255)); while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
         end else begin
            b = DIGIT_ZERO + 8'((n / div) % 10);
         end
         drive_byte(b);
         div = div / 10;
      end
   endtask

   task automatic send_message();
      int unsigned words, len, r;
      int          brk_at, brk_pos;
      r = $urandom_range(0, 99);
      if (r < 5)       words = 0;
      else if (r < 85) words = $urandom_range(1, 5);
      else if (r < 97) words = $urandom_range(6, 30);
      else             words = $urandom_range(31, 80);
      // keep the message within the remaining request budget
      if (n_sent + 4 * words > ITEMS) words = (ITEMS - n_sent) / 4;
      brk_at  = -1;
      brk_pos = -1;
      if ($urandom_range(0, 9) == 0) begin
         brk_at  = $urandom_range(0, words);
         brk_pos = $urandom_range(0, DIGITS - 1);
      end
      send_number(words, brk_at == 0 ? brk_pos : -1);
      if (brk_at == 0) return;
      for (int w = 0; w < words; w++) begin
         r = $urandom_range(0, 99);
         if (r < 10)      len = 0;
         else if (r < 90) len = $urandom_range(1, 8);
         else if (r < 98) len = $urandom_range(9, 60);
         else             len = $urandom_range(61, 250);
         if (n_sent + DIGITS + len > ITEMS) len = 0;
         send_number(len, brk_at == w + 1 ? brk_pos : -1);
         if (brk_at == w + 1) return;
         repeat (len) drive_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // stimulus
   initial begin
      bit held, drained;
      held    = 1'b0;
      drained = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[i])
         drive_byte(DIRECTED[i].in_byte, DIRECTED[i].typed, DIRECTED[i].has_rsp,
                    DIRECTED[i].rsp);
      while (n_sent < ITEMS) begin
         if (!held && n_sent >= 400) begin
            held         = 1'b1;
            hold_off_req = 1'b1;
            tx_calm      = 1'b1;
         end else if (!drained && n_sent >= 800) begin
            drained   = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_words_q.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 4)) drive_byte(8'($urandom_range(0, 255)));
         else
            send_message();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d requests and %0d responses: %0d payload bytes, %0d empty words,",
               n_req, n_rsp, n_payload, n_empty);
      $display("%0d zero-count messages, %0d header errors, %0d messages closed, top word %0d",
               n_zero_count, n_hdr_err, n_msg_end, max_word);
      if (n_fail == 0 && expected_words_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures, %0d responses still expected", n_fail,
                  expected_words_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // response side back-pressure
   initial begin
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall   <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            n = pick_gap(rx_calm);
            rsp_stall <= (n != 0);
            repeat (n == 0 ? 1 : n) @(posedge clock);
         end
      end
   end

   // prediction, checking and watchdog
   always @(posedge clock) begin
      result_type exp_r, got_r;
      bit         due;
      string      bad;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            n_req++;
            due = deframe_byte(req_in_byte, exp_r);
            if (tag_typed) begin
               due   = tag_has_rsp;
               exp_r = tag_rsp;
            end
            if (due) expected_words_q = {expected_words_q, exp_r};
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            n_rsp++;
            got_r = '{rsp_out_byte, rsp_byte_valid, rsp_end_of_word, rsp_end_of_message,
                      rsp_word_number, rsp_header_error};
            if (got_r.byte_valid) n_payload++;
            if (!got_r.byte_valid && got_r.end_of_word) n_empty++;
            if (!got_r.byte_valid && !got_r.end_of_word && got_r.end_of_message)
               n_zero_count++;
            if (got_r.header_error) n_hdr_err++;
            if (got_r.end_of_message) n_msg_end++;
            if (got_r.word_number > max_word) max_word = 32'(got_r.word_number);
            if (expected_words_q.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("%0t: response with nothing expected: %h", $realtime, got_r);
            end else begin
               exp_r = expected_words_q.pop_front();
               bad   = "";
               if (got_r.out_byte       !== exp_r.out_byte)       bad = {bad, " out_byte"};
               if (got_r.byte_valid     !== exp_r.byte_valid)     bad = {bad, " byte_valid"};
               if (got_r.end_of_word    !== exp_r.end_of_word)    bad = {bad, " end_of_word"};
               if (got_r.end_of_message !== exp_r.end_of_message) bad = {bad, " end_of_message"};
               if (got_r.word_number    !== exp_r.word_number)    bad = {bad, " word_number"};
               if (got_r.header_error   !== exp_r.header_error)   bad = {bad, " header_error"};
               if (bad != "") begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("%0t: mismatch in%s: exp %h/%b/%b/%b/%0d/%b got %h/%b/%b/%b/%0d/%b",
                              $realtime, bad, exp_r.out_byte, exp_r.byte_valid,
                              exp_r.end_of_word, exp_r.end_of_message, exp_r.word_number,
                              exp_r.header_error, got_r.out_byte, got_r.byte_valid,
                              got_r.end_of_word, got_r.end_of_message, got_r.word_number,
                              got_r.header_error);
               end
            end
         end
         if (idle_cycles >= LIMIT) begin
            $display("timeout: no request or response moved for %0d cycles", LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
